FILE: hw/rtl/rsa_pkg.sv
// Shared types and constants for the RSA exponentiation block.
// No dependencies; imported by every module of the block.
`default_nettype none

package rsa_pkg;

  parameter int RSA_WIDTH = 32;

  // Register map of the configuration port
  localparam int CFG_IDX_W = 2;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_MODULUS   = 2'd0;
  localparam cfg_idx_t CFG_PUB_EXP   = 2'd1;
  localparam cfg_idx_t CFG_PRIV_EXP  = 2'd2;

  // Register reset values
  localparam logic [63:0] MODULUS_RST  = 64'd14;
  localparam logic [63:0] PUB_EXP_RST  = 64'd5;
  localparam logic [63:0] PRIV_EXP_RST = 64'd11;

  // Request types
  localparam logic REQ_ENCRYPT = 1'b0;
  localparam logic REQ_DECRYPT = 1'b1;

  // Status of the shared modular multiplier
  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/rsa_modular_exponentiation.sv
// RSA modular exponentiation, left-to-right square-and-multiply on one shared multiplier.
// The steps are one reduction of the input, WIDTH squares and one multiply per set exponent bit,
// each a product from the multiplier; a zero modulus gives a zero result without the multiplier.
// One request at a time; busy is high throughout.
// The result is shown for one cycle on out_valid; the receiver cannot stall it.
// Synchronous active-low reset restores the registers to n=14, e=5, d=11 and goes idle.
`default_nettype none

module rsa_modular_exponentiation import rsa_pkg::*; #(
  parameter int WIDTH = RSA_WIDTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic             in_req_type,
  input  wire logic [WIDTH-1:0] in_value,
  output logic                  out_valid,
  output logic [WIDTH-1:0]      out_result,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire cfg_idx_t         cfg_index,
  input  wire logic [WIDTH-1:0] cfg_data
);

  localparam int CNT_W = $clog2(WIDTH + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RED  = 5'b00010,
    S_SQR  = 5'b00100,
    S_MUL  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t           state_r, state_nxt;
  logic             issue_r, issue_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [WIDTH-1:0] acc_r, acc_nxt;
  logic [WIDTH-1:0] base_r, base_nxt;
  logic [WIDTH-1:0] ex_r, ex_nxt;

  logic [WIDTH-1:0] modulus, pub_exp, priv_exp;
  logic [WIDTH-1:0] one;
  logic             accept;
  logic             mul_go;
  logic [WIDTH-1:0] mul_a, mul_b, mul_res;
  mul_stat_t        mul_stat;

  assign cfg_ready = 1'b1;

  rsa_cfg_regs #(.WIDTH(WIDTH)) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .modulus  (modulus),
    .pub_exp  (pub_exp),
    .priv_exp (priv_exp)
  );

  // 1 mod n; also the multiplicand that reduces the input value
  assign one    = (modulus == WIDTH'(1)) ? '0 : WIDTH'(1);
  assign accept = start && (state_r == S_IDLE);

  assign mul_go = (accept && modulus != '0) || issue_r;
  assign mul_a  = (state_r == S_IDLE) ? one : acc_r;
  assign mul_b  = (state_r == S_IDLE) ? in_value :
                  (state_r == S_SQR)  ? acc_r : base_r;

  rsa_modmul #(.WIDTH(WIDTH)) u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (mul_go),
    .a      (mul_a),
    .b      (mul_b),
    .n      (modulus),
    .stat   (mul_stat),
    .result (mul_res)
  );

  always_comb begin
    state_nxt = state_r;
    issue_nxt = 1'b0;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    base_nxt  = base_r;
    ex_nxt    = ex_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          ex_nxt  = (in_req_type == REQ_DECRYPT) ? priv_exp : pub_exp;
          cnt_nxt = CNT_W'(WIDTH);
          if (modulus == '0) begin
            acc_nxt   = '0;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_RED;
          end
        end
      end
      S_RED: begin
        if (mul_stat.done) begin
          base_nxt  = mul_res;
          acc_nxt   = one;
          state_nxt = S_SQR;
          issue_nxt = 1'b1;
        end
      end
      S_SQR: begin
        if (mul_stat.done) begin
          acc_nxt = mul_res;
          if (ex_r[WIDTH-1]) begin
            state_nxt = S_MUL;
            issue_nxt = 1'b1;
          end else begin
            // advance to the next exponent bit
            ex_nxt  = {ex_r[WIDTH-2:0], 1'b0};
            cnt_nxt = cnt_r - CNT_W'(1);
            if (cnt_r == CNT_W'(1)) begin
              state_nxt = S_DONE;
            end else begin
              issue_nxt = 1'b1;
            end
          end
        end
      end
      S_MUL: begin
        if (mul_stat.done) begin
          acc_nxt = mul_res;
          ex_nxt  = {ex_r[WIDTH-2:0], 1'b0};
          cnt_nxt = cnt_r - CNT_W'(1);
          if (cnt_r == CNT_W'(1)) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_SQR;
            issue_nxt = 1'b1;
          end
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      issue_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      issue_r <= issue_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    base_r <= base_nxt;
    ex_r   <= ex_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_valid  = (state_r == S_DONE);
  assign out_result = acc_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n) accept |=> busy)
    else $error("request accepted without going busy");
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n) out_valid |=> !busy)
    else $error("result strobe not followed by idle");
  a_go_free: assert property (@(posedge clk) disable iff (!rst_n)
    mul_go |-> !mul_stat.busy)
    else $error("multiplier launched while busy");
  a_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    mul_stat.done |-> (state_r == S_RED || state_r == S_SQR || state_r == S_MUL))
    else $error("multiplier result with no operation pending");
  a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && modulus != '0) |-> out_result < modulus)
    else $error("result not reduced modulo n");

endmodule

`default_nettype wire

FILE: hw/rtl/rsa_cfg_regs.sv
// Configuration register file: modulus and the two exponents.
// Depends on rsa_pkg for the register map and reset values.
`default_nettype none

module rsa_cfg_regs import rsa_pkg::*; #(
  parameter int WIDTH = RSA_WIDTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  input  wire cfg_idx_t         wr_index,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic [WIDTH-1:0]      modulus,
  output logic [WIDTH-1:0]      pub_exp,
  output logic [WIDTH-1:0]      priv_exp
);

  logic [WIDTH-1:0] modulus_r;
  logic [WIDTH-1:0] pub_exp_r;
  logic [WIDTH-1:0] priv_exp_r;

  // Drop writes to indexes beyond the register map
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r  <= WIDTH'(MODULUS_RST);
      pub_exp_r  <= WIDTH'(PUB_EXP_RST);
      priv_exp_r <= WIDTH'(PRIV_EXP_RST);
    end else if (wr_en) begin
      case (wr_index)
        CFG_MODULUS:  modulus_r  <= wr_data;
        CFG_PUB_EXP:  pub_exp_r  <= wr_data;
        CFG_PRIV_EXP: priv_exp_r <= wr_data;
        default: ;
      endcase
    end
  end

  assign modulus  = modulus_r;
  assign pub_exp  = pub_exp_r;
  assign priv_exp = priv_exp_r;

endmodule

`default_nettype wire

FILE: hw/rtl/rsa_modmul.sv
// Shared modular multiplier: (a * b) mod n by interleaved shift-add,
// one multiplier bit per cycle. Depends on rsa_pkg for the status struct.
`default_nettype none

module rsa_modmul import rsa_pkg::*; #(
  parameter int WIDTH = RSA_WIDTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             go,
  input  wire logic [WIDTH-1:0] a,
  input  wire logic [WIDTH-1:0] b,
  input  wire logic [WIDTH-1:0] n,
  output mul_stat_t             stat,
  output logic [WIDTH-1:0]      result
);

  localparam int CNT_W = $clog2(WIDTH + 1);

  // (x + y) mod m for x, y < m; the carry bit covers the wrap
  function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] x,
                                               input logic [WIDTH-1:0] y,
                                               input logic [WIDTH-1:0] m);
    logic [WIDTH:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[WIDTH-1:0];
  endfunction

  logic [WIDTH-1:0] a_r, b_r, n_r, r_r;
  logic [WIDTH-1:0] b_nxt, r_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [WIDTH-1:0] dbl;
  logic [WIDTH-1:0] step;

  assign dbl  = add_mod(r_r, r_r, n_r);
  assign step = b_r[WIDTH-1] ? add_mod(dbl, a_r, n_r) : dbl;

  always_comb begin
    b_nxt    = b_r;
    r_nxt    = r_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (go) begin
      b_nxt    = b;
      r_nxt    = '0;
      cnt_nxt  = CNT_W'(WIDTH);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      r_nxt   = step;
      b_nxt   = {b_r[WIDTH-2:0], 1'b0};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      a_r <= a;
      n_r <= n;
    end
    b_r <= b_nxt;
    r_r <= r_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign result    = r_r;

  a_go_busy: assert property (@(posedge clk) disable iff (!rst_n) go |=> busy_r)
    else $error("multiplier did not start on go");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n) done_r |-> !busy_r)
    else $error("multiplier done while still busy");
  a_busy_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r != '0)
    else $error("multiplier busy with empty bit count");
  a_done_range: assert property (@(posedge clk) disable iff (!rst_n)
    (done_r && n_r != '0) |-> r_r < n_r)
    else $error("modular product not reduced");

endmodule

`default_nettype wire
